// ----- hw/rtl/packed_rgb_lane_alu_defines.svh -----
// assertion macros used by the checker file
`ifndef PACKED_RGB_LANE_ALU_DEFINES_SVH
`define PACKED_RGB_LANE_ALU_DEFINES_SVH

// same-cycle implication, off while reset is active
`define PRLA_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prla check failed");

// next-cycle implication, off while reset is active
`define PRLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prla check failed");

// next-cycle implication, active through reset
`define PRLA_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("prla check failed");

`endif

// ----- hw/rtl/prla_pkg.sv -----
// shared types, commands and defaults of the packed rgb lane alu
`default_nettype none

package prla_pkg;

    localparam int LANE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF = 8;

    // pack saturates any lane at or above this value
    localparam int CLAMP_LIMIT = 256;
    localparam logic [7:0] BYTE_MAX = 8'hff;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_UNPACK = 3'd0;
    localparam t_cmd CMD_PACK   = 3'd1;
    localparam t_cmd CMD_BCAST  = 3'd2;
    localparam t_cmd CMD_ADDI   = 3'd3;
    localparam t_cmd CMD_ADD    = 3'd4;
    localparam t_cmd CMD_SUB    = 3'd5;
    localparam t_cmd CMD_MUL    = 3'd6;

    typedef enum logic [1:0] {
        LOP_ADD,
        LOP_SUB,
        LOP_ADDI,
        LOP_MUL
    } t_lane_op;

    typedef struct packed {
        logic     adv;
        t_lane_op op;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/packed_rgb_lane_alu.sv -----
// packed rgb lane alu: four-stage pipeline over three packed color lanes
//
//   channel  valid     ready     payload
//   in       i_valid   o_ready   i_cmd i_operand_a i_operand_b i_immediate i_alpha_in
//   out      o_valid   i_ready   o_result
//
// one transfer in per cycle unless a stalled output holds the pipeline
// stages: input register, lane multiply or add, rounding and lane select, output mux
// the lane multiplier stage sets the clock; the other stages hold lighter logic
// reset clears the stage valid bits only; payload registers carry no reset
// a stalled output holds the whole pipeline; o_ready falls only while o_valid waits
`default_nettype none

module packed_rgb_lane_alu #(
    parameter int LANE_BITS = prla_pkg::LANE_BITS_DEF,
    parameter int FRAC_BITS = prla_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire prla_pkg::t_cmd  i_cmd,
    input  wire [31:0]           i_operand_a,
    input  wire [29:0]           i_operand_b,
    input  wire signed [11:0]    i_immediate,
    input  wire [7:0]            i_alpha_in,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [31:0]          o_result
);
    import prla_pkg::*;

    localparam int XW = 3 * LANE_BITS + 32;

    logic                 w_adv;
    logic                 r1_v, r2_v, r3_v, r4_v;
    t_cmd                 r1_cmd, r2_cmd, r3_cmd;
    logic [31:0]          r1_a;
    logic [29:0]          r1_b;
    logic [11:0]          r1_imm;
    logic [7:0]           r1_alpha;
    logic [31:0]          r2_word, r3_word, r4_result;
    logic [31:0]          n_word, n_result;
    logic [XW-1:0]        w_a_ext, w_b_ext, w_lanes_ext, w_spread;
    logic [31:0]          w_imm_ext;
    logic [7:0]           w_clamp [3];
    logic [LANE_BITS-1:0] w_lane [3];
    t_lane_ctl            w_ctl;

    assign w_adv   = !r4_v || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r4_v;
    assign o_result = r4_result;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_cmd   <= i_cmd;
            r1_a     <= i_operand_a;
            r1_b     <= i_operand_b;
            r1_imm   <= i_immediate;
            r1_alpha <= i_alpha_in;
        end
    end

    // operand a and b bits above their own width read as zero; the immediate is sign-extended
    assign w_a_ext   = {{(XW-32){1'b0}}, r1_a};
    assign w_b_ext   = {{(XW-30){1'b0}}, r1_b};
    assign w_imm_ext = {{20{r1_imm[11]}}, r1_imm};

    always_comb begin
        case (r1_cmd)
            CMD_ADD:  w_ctl.op = LOP_ADD;
            CMD_SUB:  w_ctl.op = LOP_SUB;
            CMD_ADDI: w_ctl.op = LOP_ADDI;
            CMD_MUL:  w_ctl.op = LOP_MUL;
            default:  w_ctl.op = LOP_ADD;
        endcase
        w_ctl.adv = w_adv;
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        prla_lane #(
            .LANE_BITS (LANE_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_a    (w_a_ext[k*LANE_BITS +: LANE_BITS]),
            .i_b    (w_b_ext[k*LANE_BITS +: LANE_BITS]),
            .i_imm  (w_imm_ext[LANE_BITS-1:0]),
            .o_lane (w_lane[k])
        );
    end

    // non-arithmetic results: unpack, pack, broadcast
    always_comb begin
        w_spread = '0;
        for (int k = 0; k < 3; k++) begin
            if (w_a_ext[k*LANE_BITS +: LANE_BITS] >= LANE_BITS'(CLAMP_LIMIT)) begin
                w_clamp[k] = BYTE_MAX;
            end else begin
                w_clamp[k] = w_a_ext[k*LANE_BITS +: 8];
            end
            if (r1_cmd == CMD_UNPACK) begin
                w_spread[k*LANE_BITS +: LANE_BITS] =
                    {{(LANE_BITS-8){1'b0}}, r1_a[k*8 +: 8]};
            end else begin
                w_spread[k*LANE_BITS +: LANE_BITS] = r1_a[LANE_BITS-1:0];
            end
        end
        case (r1_cmd)
            CMD_UNPACK, CMD_BCAST: n_word = w_spread[31:0];
            CMD_PACK:              n_word = {r1_alpha, w_clamp[2], w_clamp[1], w_clamp[0]};
            default:               n_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_cmd  <= r1_cmd;
            r2_word <= n_word;
            r3_cmd  <= r2_cmd;
            r3_word <= r2_word;
        end
    end

    always_comb begin
        w_lanes_ext = '0;
        for (int k = 0; k < 3; k++) begin
            w_lanes_ext[k*LANE_BITS +: LANE_BITS] = w_lane[k];
        end
        case (r3_cmd)
            CMD_ADDI, CMD_ADD, CMD_SUB, CMD_MUL: n_result = w_lanes_ext[31:0];
            default:                             n_result = r3_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/prla_lane.sv -----
// one lane datapath: product or add/sub stage, then rounding and select stage
`default_nettype none

module prla_lane #(
    parameter int LANE_BITS = prla_pkg::LANE_BITS_DEF,
    parameter int FRAC_BITS = prla_pkg::FRAC_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire prla_pkg::t_lane_ctl i_ctl,
    input  wire [LANE_BITS-1:0]      i_a,
    input  wire [LANE_BITS-1:0]      i_b,
    input  wire [LANE_BITS-1:0]      i_imm,
    output logic [LANE_BITS-1:0]     o_lane
);
    import prla_pkg::*;

    logic [2*LANE_BITS-1:0] r_prod;
    logic [LANE_BITS-1:0]   r_sum;
    t_lane_op               r_op;
    logic [LANE_BITS-1:0]   n_sum;
    logic [LANE_BITS-1:0]   w_round;

    always_comb begin
        case (i_ctl.op)
            LOP_SUB:  n_sum = i_a - i_b;
            LOP_ADDI: n_sum = i_a + i_imm;
            default:  n_sum = i_a + i_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= (2*LANE_BITS)'(i_a) * (2*LANE_BITS)'(i_b);
            r_sum  <= n_sum;
            r_op   <= i_ctl.op;
        end
    end

    // round half up on the dropped fraction, wrap to lane width
    assign w_round = r_prod[FRAC_BITS+LANE_BITS-1:FRAC_BITS]
                   + LANE_BITS'(r_prod[FRAC_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            o_lane <= (r_op == LOP_MUL) ? w_round : r_sum;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/prla_check.sv -----
// port-level checks of the packed rgb lane alu, bound to the top level
`default_nettype none

`include "packed_rgb_lane_alu_defines.svh"

module prla_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [31:0] o_result
);

    `PRLA_ASSERT_RST(a_rst_clears_out, i_clk, !i_rst_n, !o_valid)

    `PRLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result))

    // input side stalls only while a finished result waits
    `PRLA_ASSERT(a_ready_follows_out, i_clk, i_rst_n, 1'b1, o_ready == (!o_valid || i_ready))

    // an input transfer, with o_ready high at each later stage advance, shows up at the output
    `PRLA_ASSERT_NXT(a_latency, i_clk, i_rst_n, (i_valid && o_ready) ##1 o_ready ##1 o_ready ##1 o_ready, o_valid)

endmodule

bind packed_rgb_lane_alu prla_check u_prla_check (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for the packed rgb lane alu: directed table plus random traffic, checked in order
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prla_pkg::*;

    localparam int LANE_W = LANE_BITS_DEF;
    localparam int FRAC_W = FRAC_BITS_DEF;
    localparam t_cmd CMD_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 530;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        t_cmd               cmd;
        logic [31:0]        a;
        logic [29:0]        b;
        logic signed [11:0] imm;
        logic [7:0]         alpha;
        bit                 known;
        logic [31:0]        want;
    } t_row;

    typedef struct {
        int          item;
        t_cmd        cmd;
        logic [31:0] value;
    } t_expected;

    // rows with known set carry a result read straight off the operation
    localparam t_row DIRECTED_ROWS [21] = '{
        '{CMD_UNPACK, 32'hffff_ffff, 30'h0,         12'sh000, 8'h00, 1'b1, 32'h0ff3_fcff},
        '{CMD_UNPACK, 32'h0000_0000, 30'h3fff_ffff, 12'sh7ff, 8'hff, 1'b1, 32'h0000_0000},
        '{CMD_PACK,   32'h3fff_ffff, 30'h0,         12'sh000, 8'hff, 1'b1, 32'hffff_ffff},
        '{CMD_PACK,   32'hc000_0000, 30'h3fff_ffff, 12'sh800, 8'h00, 1'b1, 32'h0000_0000},
        // red exactly at the clamp limit, green just under it
        '{CMD_PACK,   32'h1003_fc00, 30'h0,         12'sh000, 8'h5a, 1'b1, 32'h5aff_ff00},
        '{CMD_BCAST,  32'hffff_ffff, 30'h0,         12'sh000, 8'h00, 1'b1, 32'h3fff_ffff},
        '{CMD_BCAST,  32'h8000_0155, 30'h2aaa_aaaa, 12'sh000, 8'h00, 1'b0, 32'h0},
        '{CMD_ADDI,   32'h0000_0000, 30'h0,         12'shfff, 8'h00, 1'b1, 32'h3fff_ffff},
        '{CMD_ADDI,   32'h3fff_ffff, 30'h0,         12'sh001, 8'h00, 1'b1, 32'h0000_0000},
        '{CMD_ADDI,   32'h1234_5678, 30'h0,         12'sh800, 8'h00, 1'b0, 32'h0},
        '{CMD_ADDI,   32'h0010_0401, 30'h0,         12'sh7ff, 8'h00, 1'b0, 32'h0},
        '{CMD_ADD,    32'h3fff_ffff, 30'h0010_0401, 12'sh000, 8'h00, 1'b1, 32'h0000_0000},
        '{CMD_ADD,    32'h0000_0000, 30'h0000_0000, 12'sh000, 8'h00, 1'b1, 32'h0000_0000},
        '{CMD_SUB,    32'h0000_0000, 30'h0010_0401, 12'sh000, 8'h00, 1'b1, 32'h3fff_ffff},
        '{CMD_SUB,    32'hc000_0000, 30'h0000_0000, 12'sh000, 8'h00, 1'b1, 32'h0000_0000},
        '{CMD_MUL,    32'h3fff_ffff, 30'h3fff_ffff, 12'sh000, 8'h00, 1'b0, 32'h0},
        // multiply by one in every lane
        '{CMD_MUL,    32'h2345_6789, 30'h1004_0100, 12'sh000, 8'h00, 1'b0, 32'h0},
        // discarded fraction exactly one half, then just below it
        '{CMD_MUL,    32'h0010_0401, 30'h0802_0080, 12'sh000, 8'h00, 1'b0, 32'h0},
        '{CMD_MUL,    32'h0010_0401, 30'h07f1_fc7f, 12'sh000, 8'h00, 1'b0, 32'h0},
        '{CMD_MUL,    32'h0000_0000, 30'h3fff_ffff, 12'sh000, 8'h00, 1'b1, 32'h0000_0000},
        '{CMD_UNUSED, 32'hffff_ffff, 30'h3fff_ffff, 12'shfff, 8'hff, 1'b1, 32'h0000_0000}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    t_cmd               i_cmd;
    logic [31:0]        i_operand_a;
    logic [29:0]        i_operand_b;
    logic signed [11:0] i_immediate;
    logic [7:0]         i_alpha_in;
    logic               o_valid;
    logic               i_ready;
    logic [31:0]        o_result;

    t_expected expected_results[$];
    int        err_cnt;
    int        cycle_cnt;
    int        item_cnt;
    bit        burst_mode;

    packed_rgb_lane_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_immediate (i_immediate),
        .i_alpha_in  (i_alpha_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] lane_alu_result(t_cmd cmd, logic [31:0] a, logic [29:0] b,
                                                    logic signed [11:0] imm, logic [7:0] alpha);
        logic [LANE_W-1:0]   la;
        logic [LANE_W-1:0]   lb;
        logic [LANE_W-1:0]   lr;
        logic [2*LANE_W-1:0] prod;
        logic [31:0]         res;
        res = '0;
        if (cmd == CMD_PACK) begin
            res[31:24] = alpha;
            for (int k = 0; k < 3; k++) begin
                la = a[k*LANE_W +: LANE_W];
                res[k*8 +: 8] = (la >= CLAMP_LIMIT) ? BYTE_MAX : la[7:0];
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                la = a[k*LANE_W +: LANE_W];
                lb = b[k*LANE_W +: LANE_W];
                case (cmd)
                    CMD_UNPACK: lr = LANE_W'(a[k*8 +: 8]);
                    CMD_BCAST:  lr = a[LANE_W-1:0];
                    // the sign extension above the lane drops out modulo the lane size
                    CMD_ADDI:   lr = la + LANE_W'(imm);
                    CMD_ADD:    lr = la + lb;
                    CMD_SUB:    lr = la - lb;
                    CMD_MUL: begin
                        prod = (2*LANE_W)'(la) * (2*LANE_W)'(lb);
                        lr = LANE_W'(prod >> FRAC_W) + LANE_W'(prod[FRAC_W-1]);
                    end
                    default:    lr = '0;
                endcase
                res[k*LANE_W +: LANE_W] = lr;
            end
        end
        return res;
    endfunction

    // lane values weighted toward the clamp limit, rounding edges and the extremes
    function automatic logic [31:0] random_lanes();
        logic [31:0] w;
        w = $urandom;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0: w[k*LANE_W +: LANE_W] = '0;
                1: w[k*LANE_W +: LANE_W] = '1;
                2: w[k*LANE_W +: LANE_W] = LANE_W'($urandom_range(254, 257));
                3: w[k*LANE_W +: LANE_W] = LANE_W'($urandom_range(126, 129));
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic send_item(input t_row row);
        int        gap;
        t_expected exp_item;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= row.cmd;
        i_operand_a <= row.a;
        i_operand_b <= row.b;
        i_immediate <= row.imm;
        i_alpha_in  <= row.alpha;
        do @(posedge i_clk); while (!o_ready);
        exp_item.item  = item_cnt;
        exp_item.cmd   = row.cmd;
        exp_item.value = row.known ? row.want
                       : lane_alu_result(row.cmd, row.a, row.b, row.imm, row.alpha);
        expected_results.push_back(exp_item);
        item_cnt++;
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic collect_results();
        int        stall;
        t_expected exp_item;
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %08h with no item outstanding", o_result));
            end else begin
                exp_item = expected_results.pop_front();
                if (o_result !== exp_item.value)
                    report_mismatch($sformatf("item %0d cmd %0d: result %08h, want %08h",
                                              exp_item.item, exp_item.cmd, o_result,
                                              exp_item.value));
            end
        end
    endtask

    initial begin
        t_row row;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_cmd       = CMD_UNPACK;
        i_operand_a = '0;
        i_operand_b = '0;
        i_immediate = '0;
        i_alpha_in  = '0;
        err_cnt     = 0;
        cycle_cnt   = 0;
        item_cnt    = 0;
        burst_mode  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            collect_results();
        join_none

        foreach (DIRECTED_ROWS[n]) send_item(DIRECTED_ROWS[n]);
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // some stretches run back to back on both sides
            burst_mode = ((n / 50) % 5 == 2);
            if (n == RANDOM_ITEMS / 2) wait_all_results();
            row.cmd   = ($urandom_range(0, 40) == 0) ? CMD_UNUSED : t_cmd'($urandom_range(0, 6));
            row.a     = ($urandom_range(0, 3) == 0) ? $urandom : random_lanes();
            row.b     = 30'(($urandom_range(0, 3) == 0) ? $urandom : random_lanes());
            row.imm   = 12'($urandom);
            row.alpha = 8'($urandom);
            row.known = 1'b0;
            row.want  = '0;
            send_item(row);
        end

        burst_mode = 1'b1;
        wait_all_results();
        // catch anything extra the pipeline still lets out
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- packed_rgb_lane_alu.f -----
+incdir+hw/rtl
hw/rtl/prla_pkg.sv
hw/rtl/prla_lane.sv
hw/rtl/packed_rgb_lane_alu.sv
hw/rtl/prla_check.sv
sim/tb_top.sv
